[sv/pfx_pkg.sv]
package pfx_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH  = 128;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 64;

  // Saturation limits of signed Q32.32.
  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_POP_R, S_POP_L, S_OP, S_CALC, S_FIN, S_GET
  } state_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_FIN, A_DONE
  } alu_state_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic             start;
    op_t              op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_ctl_t;

  // Answer from the arithmetic unit.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
    status_t          err;
  } alu_sts_t;

endpackage

[sv/postfix_expression_evaluator_top.sv]
// Throughput: one item at a time; the rate is set by the one-bit-per-cycle divider
// (96 steps) and by the stack memory, whose single read port serves one pop per cycle.
// Reset (synchronous, rst_n low) empties the stack and clears the error status;
// stack memory contents are not cleared.
module postfix_expression_evaluator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // end_of_expression
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] value, [66:64] status, rest zero
);

  localparam int unsigned AW = pfx_pkg::ADDR_W;
  localparam int unsigned CW = pfx_pkg::CNT_W;
  localparam int unsigned W  = pfx_pkg::VAL_W;

  pfx_pkg::state_t  st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  pfx_pkg::status_t err_r, err_nxt;
  logic [7:0]       sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic             hit_r, hit_nxt;
  logic [W-1:0]     rhs_r, rhs_nxt;
  logic             ov_r, ov_nxt;
  logic [W-1:0]     oval_r, oval_nxt;
  pfx_pkg::status_t ost_r, ost_nxt;

  logic             flag;
  pfx_pkg::status_t flag_code;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [W-1:0]     wdata, rdata, popped;
  logic             accept, is_digit, is_arith, out_ld;
  logic [CW-1:0]    cnt_dec;
  pfx_pkg::alu_ctl_t alu_ctl;
  pfx_pkg::alu_sts_t alu_sts;

  pfx_ram #(.WIDTH(W), .DEPTH(pfx_pkg::DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  pfx_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .sts   (alu_sts)
  );

  assign accept   = in_tvalid && in_tready;
  assign is_digit = in_tdata inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]};
  assign is_arith = sym_r inside {pfx_pkg::CH_ADD, pfx_pkg::CH_SUB,
                                  pfx_pkg::CH_MUL, pfx_pkg::CH_DIV};
  assign cnt_dec  = cnt_r - CW'(1);
  assign popped   = hit_r ? rdata : W'(0);
  assign out_ld   = (st_r == pfx_pkg::S_GET) && (!ov_r || out_tready);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pfx_pkg::S_IDLE: begin
        if (accept) begin
          if (!is_digit)     st_nxt = pfx_pkg::S_POP_R;
          else if (in_tlast) st_nxt = pfx_pkg::S_FIN;
        end
      end
      pfx_pkg::S_POP_R: st_nxt = pfx_pkg::S_POP_L;
      pfx_pkg::S_POP_L: st_nxt = pfx_pkg::S_OP;
      pfx_pkg::S_OP: begin
        if (is_arith)    st_nxt = pfx_pkg::S_CALC;
        else if (last_r) st_nxt = pfx_pkg::S_FIN;
        else             st_nxt = pfx_pkg::S_IDLE;
      end
      pfx_pkg::S_CALC: begin
        if (alu_sts.done) st_nxt = last_r ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
      end
      pfx_pkg::S_FIN: st_nxt = pfx_pkg::S_GET;
      pfx_pkg::S_GET: if (out_ld) st_nxt = pfx_pkg::S_IDLE;
      default:        st_nxt = pfx_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_tready   = (st_r == pfx_pkg::S_IDLE);
    cnt_nxt     = cnt_r;
    sym_nxt     = sym_r;
    last_nxt    = last_r;
    hit_nxt     = hit_r;
    rhs_nxt     = rhs_r;
    ov_nxt      = ov_r && !out_tready;
    oval_nxt    = oval_r;
    ost_nxt     = ost_r;
    flag        = 1'b0;
    flag_code   = pfx_pkg::ST_OK;
    we          = 1'b0;
    waddr       = cnt_r[AW-1:0];
    wdata       = alu_sts.res;
    re          = 1'b0;
    raddr       = cnt_dec[AW-1:0];
    alu_ctl     = '{start: 1'b0, op: pfx_pkg::OP_ADD, a: popped, b: rhs_r};
    case (sym_r)
      pfx_pkg::CH_ADD: alu_ctl.op = pfx_pkg::OP_ADD;
      pfx_pkg::CH_SUB: alu_ctl.op = pfx_pkg::OP_SUB;
      pfx_pkg::CH_MUL: alu_ctl.op = pfx_pkg::OP_MUL;
      default:         alu_ctl.op = pfx_pkg::OP_DIV;
    endcase
    case (st_r)
      pfx_pkg::S_IDLE: begin
        if (accept) begin
          sym_nxt  = in_tdata;
          last_nxt = in_tlast;
          if (is_digit) begin
            // Push the digit value, or drop it when the stack is full.
            if (cnt_r == CW'(pfx_pkg::DEPTH)) begin
              flag      = 1'b1;
              flag_code = pfx_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              wdata   = {28'b0, 4'(in_tdata - pfx_pkg::CH_ZERO), 32'b0};
              cnt_nxt = cnt_r + CW'(1);
            end
          end
        end
      end
      pfx_pkg::S_POP_R, pfx_pkg::S_POP_L, pfx_pkg::S_FIN: begin
        // Issue one pop; an empty stack yields zero.
        if (st_r == pfx_pkg::S_POP_L) rhs_nxt = popped;
        if (cnt_r != CW'(0)) begin
          re      = 1'b1;
          cnt_nxt = cnt_dec;
          hit_nxt = 1'b1;
        end else begin
          hit_nxt   = 1'b0;
          flag      = 1'b1;
          flag_code = pfx_pkg::ST_UNDERFLOW;
        end
      end
      pfx_pkg::S_OP: begin
        alu_ctl.start = is_arith;
      end
      pfx_pkg::S_CALC: begin
        // Push the result; two pops came first, so there is room.
        if (alu_sts.done) begin
          we        = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          flag      = (alu_sts.err != pfx_pkg::ST_OK);
          flag_code = alu_sts.err;
        end
      end
      pfx_pkg::S_GET: begin
        if (out_ld) begin
          ov_nxt   = 1'b1;
          oval_nxt = popped;
          ost_nxt  = err_r;
          cnt_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  // Sticky status keeps the first error of an expression.
  always_comb begin
    err_nxt = err_r;
    if (out_ld) begin
      err_nxt = pfx_pkg::ST_OK;
    end else if (flag && err_r == pfx_pkg::ST_OK) begin
      err_nxt = flag_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= pfx_pkg::S_IDLE;
      cnt_r <= '0;
      err_r <= pfx_pkg::ST_OK;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      ov_r  <= ov_nxt;
    end
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    hit_r  <= hit_nxt;
    rhs_r  <= rhs_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'b0, ost_r, oval_r};

  // The fill count never passes the stack depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(pfx_pkg::DEPTH))
    else $error("stack count beyond depth");

  // Emitting a result leaves an empty stack and a clear status.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (cnt_r == CW'(0) && err_r == pfx_pkg::ST_OK && ov_r))
    else $error("state not cleared after result");

  // The arithmetic unit reports only while the sequencer waits for it.
  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_sts.done |-> st_r == pfx_pkg::S_CALC)
    else $error("arithmetic result without a waiting sequencer");

  // No stack read while the evaluator is ready for input.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !re)
    else $error("stack read while idle");

endmodule

[sv/pfx_ram.sv]
module pfx_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/pfx_alu.sv]
module pfx_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  pfx_pkg::alu_ctl_t ctl,
  output pfx_pkg::alu_sts_t sts
);

  localparam int unsigned W = pfx_pkg::VAL_W;

  pfx_pkg::alu_state_t st_r, st_nxt;
  pfx_pkg::op_t        op_r, op_nxt;
  logic                neg_r, neg_nxt;
  logic [W-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [2*W-1:0]      acc_r, acc_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        dvd_r, dvd_nxt;
  logic [W+31:0]       q_r, q_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [W-1:0]        res_r, res_nxt;
  pfx_pkg::status_t    err_r, err_nxt;

  logic [W-1:0]   sum, dif, xm, ym, mag, rem_sh;
  logic [31:0]    pa, pb;
  logic [W-1:0]   prod;
  logic [2*W-1:0] prod_sh;
  logic           big, ge;

  function automatic logic [W-1:0] absval(input logic [W-1:0] v);
    absval = v[W-1] ? (W'(0) - v) : v;
  endfunction

  assign sum = ctl.a + ctl.b;
  assign dif = ctl.a - ctl.b;
  assign xm  = absval(ctl.a);
  assign ym  = absval(ctl.b);

  // One 32x32 partial product per cycle.
  assign pa      = cnt_r[0] ? x_r[W-1:32] : x_r[31:0];
  assign pb      = cnt_r[1] ? y_r[W-1:32] : y_r[31:0];
  assign prod    = {32'b0, pa} * {32'b0, pb};
  assign prod_sh = {64'b0, prod} << (7'(cnt_r[0]) + 7'(cnt_r[1])) * 7'd32;

  // One restoring divide step per cycle.
  assign rem_sh = {rem_r[W-2:0], dvd_r[W-1]};
  assign ge     = rem_r[W-1] || (rem_sh >= y_r);

  assign big = (op_r == pfx_pkg::OP_MUL) ? (acc_r[127:96] != 32'b0) : (q_r[95:64] != 32'b0);
  assign mag = (op_r == pfx_pkg::OP_MUL) ? acc_r[95:32] : q_r[63:0];

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pfx_pkg::A_IDLE: begin
        if (ctl.start) begin
          if (ctl.op == pfx_pkg::OP_MUL) begin
            st_nxt = pfx_pkg::A_MUL;
          end else if (ctl.op == pfx_pkg::OP_DIV && ctl.b != W'(0)) begin
            st_nxt = pfx_pkg::A_DIV;
          end else begin
            st_nxt = pfx_pkg::A_DONE;
          end
        end
      end
      pfx_pkg::A_MUL:  if (cnt_r == 7'd3) st_nxt = pfx_pkg::A_FIN;
      pfx_pkg::A_DIV:  if (cnt_r == 7'd95) st_nxt = pfx_pkg::A_FIN;
      pfx_pkg::A_FIN:  st_nxt = pfx_pkg::A_DONE;
      pfx_pkg::A_DONE: st_nxt = pfx_pkg::A_IDLE;
      default:         st_nxt = pfx_pkg::A_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    op_nxt  = op_r;
    neg_nxt = neg_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    err_nxt = err_r;
    case (st_r)
      pfx_pkg::A_IDLE: begin
        op_nxt  = ctl.op;
        neg_nxt = ctl.a[W-1] ^ ctl.b[W-1];
        x_nxt   = xm;
        y_nxt   = ym;
        acc_nxt = '0;
        rem_nxt = '0;
        dvd_nxt = xm;
        q_nxt   = '0;
        cnt_nxt = '0;
        err_nxt = pfx_pkg::ST_OK;
        case (ctl.op)
          pfx_pkg::OP_ADD: begin
            res_nxt = sum;
            if (ctl.a[W-1] == ctl.b[W-1] && sum[W-1] != ctl.a[W-1]) begin
              res_nxt = ctl.a[W-1] ? pfx_pkg::NEG_MIN : pfx_pkg::POS_MAX;
              err_nxt = pfx_pkg::ST_OVERFLOW;
            end
          end
          pfx_pkg::OP_SUB: begin
            res_nxt = dif;
            if (ctl.a[W-1] != ctl.b[W-1] && dif[W-1] != ctl.a[W-1]) begin
              res_nxt = ctl.a[W-1] ? pfx_pkg::NEG_MIN : pfx_pkg::POS_MAX;
              err_nxt = pfx_pkg::ST_OVERFLOW;
            end
          end
          pfx_pkg::OP_DIV: begin
            // A zero divisor saturates toward the sign of the dividend.
            if (ctl.b == W'(0)) begin
              res_nxt = ctl.a[W-1] ? pfx_pkg::NEG_MIN : pfx_pkg::POS_MAX;
              err_nxt = pfx_pkg::ST_DIVZERO;
            end
          end
          default: ;
        endcase
      end
      pfx_pkg::A_MUL: begin
        acc_nxt = acc_r + prod_sh;
        cnt_nxt = cnt_r + 7'd1;
      end
      pfx_pkg::A_DIV: begin
        rem_nxt = ge ? (rem_sh - y_r) : rem_sh;
        q_nxt   = {q_r[W+30:0], ge};
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
      end
      pfx_pkg::A_FIN: begin
        // Apply the sign and saturate.
        if (neg_r) begin
          if (big || mag > pfx_pkg::NEG_MIN) begin
            res_nxt = pfx_pkg::NEG_MIN;
            err_nxt = pfx_pkg::ST_OVERFLOW;
          end else begin
            res_nxt = W'(0) - mag;
          end
        end else begin
          if (big || mag > pfx_pkg::POS_MAX) begin
            res_nxt = pfx_pkg::POS_MAX;
            err_nxt = pfx_pkg::ST_OVERFLOW;
          end else begin
            res_nxt = mag;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pfx_pkg::A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
  end

  assign sts.done = (st_r == pfx_pkg::A_DONE);
  assign sts.res  = res_r;
  assign sts.err  = err_r;

endmodule
